>>> rtl/heat_diffusion_stencil_defines.svh
// Assertion macros shared by the heat diffusion stencil RTL.
// Define ASSERT_OFF to compile every assertion away.
`ifndef HEAT_DIFFUSION_STENCIL_DEFINES_SVH
`define HEAT_DIFFUSION_STENCIL_DEFINES_SVH
`ifndef ASSERT_OFF
`define HDS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HDS_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HDS_ASSERT(lbl, clk, rst_n, prop, msg)
`define HDS_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/hds_pkg.sv
// Shared constants, codes and record types of the heat diffusion stencil.
// No dependencies.
package hds_pkg;

    localparam int MAX_N      = 1024;
    localparam int COL_W      = $clog2(MAX_N);
    localparam int SIZE_W     = 11;
    localparam int TEMP_W     = 16;
    localparam int RATE_W     = 15;
    localparam int OFFS_W     = 9;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // Both queue depths must be powers of two so the pointers wrap naturally.
    localparam int WQ_DEPTH = 4;
    localparam int WQ_PTR_W = $clog2(WQ_DEPTH);
    localparam int WQ_CNT_W = WQ_PTR_W + 1;
    localparam int OQ_DEPTH = 8;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = OQ_PTR_W + 1;

    localparam int LAP_W  = TEMP_W + 3;
    localparam int PROD_W = RATE_W + 1 + LAP_W;

    localparam logic [CFG_ADDR_W-1:0] REG_GRID_SIZE     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DIFF_RATE     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SOURCE_LEVEL  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SOURCE_OFFSET = 2'd3;

    localparam logic [SIZE_W-1:0] GRID_SIZE_RESET     = 11'd128;
    localparam logic [SIZE_W-1:0] GRID_SIZE_MIN       = 11'd3;
    localparam logic [RATE_W-1:0] DIFF_RATE_RESET     = 15'd16384;
    localparam logic [TEMP_W-1:0] SOURCE_LEVEL_RESET  = 16'd25600;
    localparam logic [OFFS_W-1:0] SOURCE_OFFSET_RESET = 9'd20;

    // How the back end treats the cell above the one just taken.
    localparam logic [1:0] KIND_PASS    = 2'd0;
    localparam logic [1:0] KIND_SOURCE  = 2'd1;
    localparam logic [1:0] KIND_DIFFUSE = 2'd2;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [OFFS_W-1:0] offset;
    } t_front_cfg;

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic [TEMP_W-1:0] level;
    } t_back_cfg;

    typedef struct packed {
        logic [1:0]        kind;
        logic              second;
        logic              last;
        logic [TEMP_W-1:0] centre;
        logic [TEMP_W-1:0] up;
        logic [TEMP_W-1:0] down;
        logic [TEMP_W-1:0] left;
        logic [TEMP_W-1:0] right;
    } t_work;

    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        logic              last;
    } t_result;

endpackage

>>> rtl/heat_diffusion_stencil.sv
// Heat diffusion stencil: one explicit time step over a square grid streamed
// in raster order, one cell per transfer. Results lag the input by one row:
// row 0 gives none, every later cell gives the updated cell above it, and
// last-row cells give a second, pass-through result for themselves. A cell
// is taken every cycle while the output side keeps up; on the last row the
// back end issues two results per cell through its single output write
// port, so cells cannot be taken every cycle. A cell's first result
// passes through the front stage register, the work queue, the two
// arithmetic stages and the output queue on its way to the output ports.
// The row buffers need no clearing pass after reset. Configuration must be
// written only while the block is idle; the block itself does not enforce
// this. Writing the grid size restarts the sweep at row 0, column 0.
// Depends on hds_pkg, hds_front, hds_work_fifo and hds_back.
module heat_diffusion_stencil (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [hds_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [hds_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           push,
    output logic                           full,
    input  logic [hds_pkg::TEMP_W-1:0]     i_temperature,
    input  logic                           pop,
    output logic                           empty,
    output logic [hds_pkg::TEMP_W-1:0]     o_new_temperature,
    output logic                           o_last_of_grid
);

    logic [hds_pkg::SIZE_W-1:0]   r_side_len;
    logic [hds_pkg::RATE_W-1:0]   r_diff_rate;
    logic [hds_pkg::TEMP_W-1:0]   r_source_level;
    logic [hds_pkg::OFFS_W-1:0]   r_source_offset;

    logic [hds_pkg::SIZE_W-1:0]   w_size_eff;
    logic                         w_restart;
    hds_pkg::t_front_cfg          w_front_cfg;
    hds_pkg::t_back_cfg           w_back_cfg;
    logic                         w_wq_push;
    hds_pkg::t_work               w_wq_data;
    logic                         w_wq_pop;
    hds_pkg::t_work               w_wq_head;
    logic                         w_wq_empty;
    logic [hds_pkg::WQ_CNT_W-1:0] w_wq_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_len      <= hds_pkg::GRID_SIZE_RESET;
            r_diff_rate     <= hds_pkg::DIFF_RATE_RESET;
            r_source_level  <= hds_pkg::SOURCE_LEVEL_RESET;
            r_source_offset <= hds_pkg::SOURCE_OFFSET_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                hds_pkg::REG_GRID_SIZE: begin
                    r_side_len <= i_cfg_wdata[hds_pkg::SIZE_W-1:0];
                end
                hds_pkg::REG_DIFF_RATE: begin
                    r_diff_rate <= i_cfg_wdata[hds_pkg::RATE_W-1:0];
                end
                hds_pkg::REG_SOURCE_LEVEL: begin
                    r_source_level <= i_cfg_wdata[hds_pkg::TEMP_W-1:0];
                end
                hds_pkg::REG_SOURCE_OFFSET: begin
                    r_source_offset <= i_cfg_wdata[hds_pkg::OFFS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Out-of-range grid sizes are clamped to the supported span.
    always_comb begin
        if (r_side_len < hds_pkg::GRID_SIZE_MIN) begin
            w_size_eff = hds_pkg::GRID_SIZE_MIN;
        end else if (r_side_len > hds_pkg::SIZE_W'(hds_pkg::MAX_N)) begin
            w_size_eff = hds_pkg::SIZE_W'(hds_pkg::MAX_N);
        end else begin
            w_size_eff = r_side_len;
        end
    end

    assign w_restart          = i_cfg_wr_en && (i_cfg_addr == hds_pkg::REG_GRID_SIZE);
    assign w_front_cfg.size   = w_size_eff;
    assign w_front_cfg.offset = r_source_offset;
    assign w_back_cfg.rate    = r_diff_rate;
    assign w_back_cfg.level   = r_source_level;

    hds_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_front_cfg),
        .i_restart     (w_restart),
        .i_push        (push),
        .i_temperature (i_temperature),
        .i_wq_count    (w_wq_count),
        .o_full        (full),
        .o_wq_push     (w_wq_push),
        .o_wq_data     (w_wq_data)
    );

    hds_work_fifo u_work_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_wq_push),
        .i_data  (w_wq_data),
        .i_pop   (w_wq_pop),
        .o_head  (w_wq_head),
        .o_empty (w_wq_empty),
        .o_count (w_wq_count)
    );

    hds_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (w_back_cfg),
        .i_head            (w_wq_head),
        .i_wq_empty        (w_wq_empty),
        .o_wq_pop          (w_wq_pop),
        .pop               (pop),
        .empty             (empty),
        .o_new_temperature (o_new_temperature),
        .o_last_of_grid    (o_last_of_grid)
    );

endmodule

>>> rtl/hds_front.sv
// Front end: raster position, the two row buffers, the neighbour window and
// cell classification. Uses hds_pkg and heat_diffusion_stencil_defines.svh.
`include "heat_diffusion_stencil_defines.svh"
module hds_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hds_pkg::t_front_cfg          i_cfg,
    input  logic                         i_restart,
    input  logic                         i_push,
    input  logic [hds_pkg::TEMP_W-1:0]   i_temperature,
    input  logic [hds_pkg::WQ_CNT_W-1:0] i_wq_count,
    output logic                         o_full,
    output logic                         o_wq_push,
    output hds_pkg::t_work               o_wq_data
);

    localparam int LOAD_W = hds_pkg::WQ_CNT_W + 1;
    localparam int POS_W  = hds_pkg::SIZE_W + 1;

    logic [hds_pkg::COL_W-1:0]  r_row;
    logic [hds_pkg::COL_W-1:0]  r_col;
    logic [hds_pkg::TEMP_W-1:0] r_newer_mem [hds_pkg::MAX_N];
    logic [hds_pkg::TEMP_W-1:0] r_older_mem [hds_pkg::MAX_N];
    logic [hds_pkg::TEMP_W-1:0] r_rd_newer;
    logic [hds_pkg::TEMP_W-1:0] r_rd_older;
    logic [hds_pkg::TEMP_W-1:0] r_col0;
    logic [hds_pkg::TEMP_W-1:0] r_win;

    logic                       r_s1_valid;
    logic [1:0]                 r_s1_kind;
    logic                       r_s1_second;
    logic                       r_s1_last;
    logic                       r_s1_right_zero;
    logic [hds_pkg::TEMP_W-1:0] r_s1_centre;
    logic [hds_pkg::TEMP_W-1:0] r_s1_down;
    logic [hds_pkg::TEMP_W-1:0] r_s1_left;

    logic                       w_accept;
    logic [hds_pkg::SIZE_W-1:0] w_n_m1;
    logic [hds_pkg::SIZE_W-1:0] w_n_m2;
    logic                       w_col_last;
    logic                       w_row_last;
    logic [hds_pkg::TEMP_W-1:0] w_centre;
    logic [hds_pkg::TEMP_W-1:0] w_left;
    logic [hds_pkg::COL_W-1:0]  w_right_addr;
    logic [POS_W-1:0]           w_y;
    logic [POS_W-1:0]           w_x;
    logic [POS_W-1:0]           w_c;
    logic [POS_W-1:0]           w_off;
    logic [POS_W-1:0]           w_c_plus;
    logic                       w_interior;
    logic                       w_y_hit;
    logic                       w_x_hit;
    logic                       w_source;
    logic [1:0]                 w_kind;
    logic [LOAD_W-1:0]          w_load;

    assign w_load   = {1'b0, i_wq_count} + LOAD_W'(r_s1_valid);
    assign o_full   = (w_load >= LOAD_W'(hds_pkg::WQ_DEPTH));
    assign w_accept = i_push & ~o_full;

    assign w_n_m1     = i_cfg.size - 11'd1;
    assign w_n_m2     = i_cfg.size - 11'd2;
    assign w_col_last = ({1'b0, r_col} == w_n_m1);
    assign w_row_last = ({1'b0, r_row} == w_n_m1);

    // Column 0 of the previous row lives in a register, so the newer row
    // buffer is only ever read one column ahead.
    assign w_centre     = (r_col == '0) ? r_col0 : r_rd_newer;
    assign w_left       = (r_col == '0) ? '0 : r_win;
    assign w_right_addr = r_col + 1'b1;

    // Classification of the cell one row above the incoming one.
    assign w_y      = {2'b00, r_row} - POS_W'(1);
    assign w_x      = {2'b00, r_col};
    assign w_c      = {2'b00, i_cfg.size[hds_pkg::SIZE_W-1:1]};
    assign w_off    = POS_W'(i_cfg.offset);
    assign w_c_plus = w_c + w_off;

    assign w_interior = (w_y >= POS_W'(1)) && (w_y <= {1'b0, w_n_m2})
                     && (w_x >= POS_W'(1)) && (w_x <= {1'b0, w_n_m2});
    assign w_y_hit  = (w_y == w_c_plus) || ((w_y + w_off) == w_c);
    assign w_x_hit  = (w_x == w_c_plus) || ((w_x + w_off) == w_c);
    assign w_source = ((w_y == w_c) && (w_x == w_c)) || (w_y_hit && w_x_hit);

    always_comb begin
        if (!w_interior) begin
            w_kind = hds_pkg::KIND_PASS;
        end else if (w_source) begin
            w_kind = hds_pkg::KIND_SOURCE;
        end else begin
            w_kind = hds_pkg::KIND_DIFFUSE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_restart) begin
                r_row <= '0;
                r_col <= '0;
            end else if (w_accept) begin
                if (w_col_last) begin
                    r_col <= '0;
                    r_row <= w_row_last ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            r_s1_valid <= w_accept && (r_row != '0);
        end
    end

    // Read-first row buffers: the older row is read and rewritten at the
    // same column in one transfer.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_newer_mem[r_col] <= i_temperature;
            r_older_mem[r_col] <= w_centre;
            r_rd_older         <= r_older_mem[r_col];
            r_rd_newer         <= r_newer_mem[w_right_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (r_col == '0) begin
                r_col0 <= i_temperature;
            end
            r_win           <= w_centre;
            r_s1_kind       <= w_kind;
            r_s1_second     <= w_row_last;
            r_s1_last       <= w_row_last & w_col_last;
            r_s1_right_zero <= w_col_last;
            r_s1_centre     <= w_centre;
            r_s1_down       <= i_temperature;
            r_s1_left       <= w_left;
        end
    end

    assign o_wq_push        = r_s1_valid;
    assign o_wq_data.kind   = r_s1_kind;
    assign o_wq_data.second = r_s1_second;
    assign o_wq_data.last   = r_s1_last;
    assign o_wq_data.centre = r_s1_centre;
    assign o_wq_data.up     = r_rd_older;
    assign o_wq_data.down   = r_s1_down;
    assign o_wq_data.left   = r_s1_left;
    assign o_wq_data.right  = r_s1_right_zero ? '0 : r_rd_newer;

    `HDS_ASSERT(a_s1_follows_transfer, i_clk, i_rst_n, r_s1_valid |-> $past(w_accept), "front stage valid without a transfer")
    `HDS_ASSERT(a_wq_no_overflow, i_clk, i_rst_n, o_wq_push |-> (i_wq_count < hds_pkg::WQ_CNT_W'(hds_pkg::WQ_DEPTH)), "work queue overflow")

endmodule

>>> rtl/hds_work_fifo.sv
// Short queue of classified cell records between front and back end.
// Uses hds_pkg and heat_diffusion_stencil_defines.svh.
`include "heat_diffusion_stencil_defines.svh"
module hds_work_fifo (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  hds_pkg::t_work               i_data,
    input  logic                         i_pop,
    output hds_pkg::t_work               o_head,
    output logic                         o_empty,
    output logic [hds_pkg::WQ_CNT_W-1:0] o_count
);

    localparam logic [hds_pkg::WQ_CNT_W-1:0] DEPTH_CNT = hds_pkg::WQ_CNT_W'(hds_pkg::WQ_DEPTH);

    hds_pkg::t_work                r_mem [hds_pkg::WQ_DEPTH];
    logic [hds_pkg::WQ_PTR_W-1:0]  r_wr_ptr;
    logic [hds_pkg::WQ_PTR_W-1:0]  r_rd_ptr;
    logic [hds_pkg::WQ_CNT_W-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

    `HDS_ASSERT(a_no_pop_when_empty, i_clk, i_rst_n, i_pop |-> !o_empty, "work queue popped while empty")
    `HDS_ASSERT_NORST(a_count_bound, i_clk, !i_rst_n || (r_count <= DEPTH_CNT),
                      "work queue count out of range")

endmodule

>>> rtl/hds_back.sv
// Back end: issues one result per cycle from the work queue while the output
// queue has room, computes the diffusion update in two stages and buffers
// results in the output queue. Uses hds_pkg and heat_diffusion_stencil_defines.svh.
`include "heat_diffusion_stencil_defines.svh"
module hds_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hds_pkg::t_back_cfg          i_cfg,
    input  hds_pkg::t_work              i_head,
    input  logic                        i_wq_empty,
    output logic                        o_wq_pop,
    input  logic                        pop,
    output logic                        empty,
    output logic [hds_pkg::TEMP_W-1:0]  o_new_temperature,
    output logic                        o_last_of_grid
);

    localparam int LOAD_W = hds_pkg::OQ_CNT_W + 1;
    localparam int SUM_W  = hds_pkg::TEMP_W + 2;
    localparam int Q_W    = hds_pkg::PROD_W - 16;
    localparam int V_W    = Q_W + 1;

    logic r_phase;

    logic                                    r_a_valid;
    logic                                    r_a_diff;
    logic                                    r_a_last;
    logic [hds_pkg::TEMP_W-1:0]              r_a_val;
    logic signed [hds_pkg::LAP_W-1:0]        r_a_lap;

    logic                                    r_b_valid;
    logic                                    r_b_diff;
    logic                                    r_b_last;
    logic [hds_pkg::TEMP_W-1:0]              r_b_val;
    logic signed [hds_pkg::PROD_W-1:0]       r_b_prod;

    hds_pkg::t_result                        r_oq_mem [hds_pkg::OQ_DEPTH];
    logic [hds_pkg::OQ_PTR_W-1:0]            r_oq_wr;
    logic [hds_pkg::OQ_PTR_W-1:0]            r_oq_rd;
    logic [hds_pkg::OQ_CNT_W-1:0]            r_oq_count;

    logic [LOAD_W-1:0]                       w_load;
    logic                                    w_issue;
    logic                                    w_oq_pop;
    logic [SUM_W-1:0]                        w_nsum;
    logic signed [hds_pkg::LAP_W-1:0]        w_lap;
    logic [hds_pkg::TEMP_W-1:0]              w_val;
    logic                                    w_diff;
    logic signed [Q_W-1:0]                   w_q;
    logic signed [V_W-1:0]                   w_v;
    logic [hds_pkg::TEMP_W-1:0]              w_res;
    hds_pkg::t_result                        w_oq_in;

    // Space is reserved for everything in flight, so issue never overruns
    // the output queue.
    assign w_load   = LOAD_W'(r_oq_count) + LOAD_W'(r_a_valid) + LOAD_W'(r_b_valid);
    assign w_issue  = !i_wq_empty && (w_load < LOAD_W'(hds_pkg::OQ_DEPTH));
    assign o_wq_pop = w_issue && (r_phase || !i_head.second);

    assign w_nsum = SUM_W'(i_head.up) + SUM_W'(i_head.down)
                  + SUM_W'(i_head.left) + SUM_W'(i_head.right);
    assign w_lap  = $signed({1'b0, w_nsum}) - $signed({1'b0, i_head.centre, 2'b00});

    // The second result of a last-row cell is the incoming border cell itself.
    always_comb begin
        w_diff = 1'b0;
        w_val  = i_head.centre;
        if (r_phase) begin
            w_val = i_head.down;
        end else begin
            case (i_head.kind)
                hds_pkg::KIND_PASS: begin
                    w_val = i_head.centre;
                end
                hds_pkg::KIND_SOURCE: begin
                    w_val = i_cfg.level;
                end
                hds_pkg::KIND_DIFFUSE: begin
                    w_diff = 1'b1;
                end
                default: begin
                    w_val = i_head.centre;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= 1'b0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (w_issue) begin
                r_phase <= !r_phase && i_head.second;
            end
            r_a_valid <= w_issue;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_diff <= w_diff;
        r_a_last <= r_phase & i_head.last;
        r_a_val  <= w_val;
        r_a_lap  <= w_lap;
        r_b_diff <= r_a_diff;
        r_b_last <= r_a_last;
        r_b_val  <= r_a_val;
        r_b_prod <= $signed({1'b0, i_cfg.rate}) * r_a_lap;
    end

    // An arithmetic shift rounds the scaled Laplacian toward minus infinity.
    assign w_q = r_b_prod[hds_pkg::PROD_W-1:16];
    assign w_v = $signed({{(V_W - hds_pkg::TEMP_W){1'b0}}, r_b_val}) + $signed({w_q[Q_W-1], w_q});

    always_comb begin
        if (!r_b_diff) begin
            w_res = r_b_val;
        end else if (w_v[V_W-1]) begin
            w_res = '0;
        end else if (w_v[V_W-2:hds_pkg::TEMP_W] != '0) begin
            w_res = '1;
        end else begin
            w_res = w_v[hds_pkg::TEMP_W-1:0];
        end
    end

    assign w_oq_in.temp = w_res;
    assign w_oq_in.last = r_b_last;
    assign w_oq_pop     = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wr    <= '0;
            r_oq_rd    <= '0;
            r_oq_count <= '0;
        end else begin
            if (r_b_valid) begin
                r_oq_wr <= r_oq_wr + 1'b1;
            end
            if (w_oq_pop) begin
                r_oq_rd <= r_oq_rd + 1'b1;
            end
            if (r_b_valid && !w_oq_pop) begin
                r_oq_count <= r_oq_count + 1'b1;
            end else if (!r_b_valid && w_oq_pop) begin
                r_oq_count <= r_oq_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_oq_mem[r_oq_wr] <= w_oq_in;
        end
    end

    assign empty             = (r_oq_count == '0);
    assign o_new_temperature = r_oq_mem[r_oq_rd].temp;
    assign o_last_of_grid    = r_oq_mem[r_oq_rd].last;

    `HDS_ASSERT(a_oq_no_overflow, i_clk, i_rst_n, r_b_valid |-> ((r_oq_count < hds_pkg::OQ_CNT_W'(hds_pkg::OQ_DEPTH)) || w_oq_pop), "output queue overflow")
    `HDS_ASSERT(a_second_has_head, i_clk, i_rst_n, r_phase |-> !i_wq_empty, "second result pending without a queued record")

endmodule
